// ----- sv/gsv_pkg.sv -----
// Shared types and constants for the GSV sentence field parser.
// No dependencies.
package gsv_pkg;

   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [2:0] POS_INVIEW = 3'd2;
   localparam logic [2:0] POS_ID     = 3'd3;
   localparam logic [2:0] POS_ELEV   = 3'd4;
   localparam logic [2:0] POS_AZ     = 3'd5;
   localparam logic [2:0] POS_SNR    = 3'd6;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_SYNTAX = 2'd1;
   localparam logic [1:0] ST_NUMBER = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   localparam logic [10:0] ACC_MAX = 11'd2047;

   // Search request handed along the cell chain.
   typedef struct packed {
      logic       active;
      logic [9:0] id;
      logic       found;
      logic       free_seen;
   } search_type;

endpackage

// ----- sv/gsv_sentence_field_parser_core.sv -----
// GSV sentence parser top level: field parsing, satellite table and result output.
// Depends on gsv_pkg and gsv_cell.
//
// A byte that closes no field, or a field that changes no record, yields no result word.
// A byte that closes a well-formed elevation, azimuth or SNR field of a selected satellite
// stores its value and yields one result word. A byte that closes a non-empty well-formed
// id field walks the search word through the MAX_SATS table cells, one cell per cycle.
// A last byte also yields a status word. The input also waits while a result word is
// not taken, so a stalled receiver stalls the input.
module gsv_sentence_field_parser_core #(
   parameter int MAX_SATS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_last_byte,
   input  logic [31:0] req_utc_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_sats_in_view,
   output logic [9:0]  rsp_sat_id,
   output logic [4:0]  rsp_table_slot,
   output logic signed [7:0] rsp_elevation_deg,
   output logic        rsp_elevation_ok,
   output logic [8:0]  rsp_azimuth_deg,
   output logic        rsp_azimuth_ok,
   output logic [6:0]  rsp_snr_db,
   output logic [31:0] rsp_reported_time
);
   localparam int SW = $clog2(MAX_SATS);
   localparam int CW = $clog2(MAX_SATS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SEARCH, S_REC, S_REC_OUT, S_STAT_OUT
   } state_type;

   state_type state_ff;
   logic [2:0]  pos_ff;
   logic [10:0] acc_ff;
   logic        empty_ff, neg_ff, bad_ff;
   logic        sel_ff;
   logic [SW-1:0] slot_ff;
   logic [7:0]  view_ff;
   logic [1:0]  skip_ff;
   logic        last_ff;
   logic [31:0] utc_ff;
   logic [9:0]  sid_ff;
   logic [CW-1:0] cnt_ff;
   logic        found_ff, free_ff;
   logic [SW-1:0] fslot_ff, eslot_ff;
   logic [1:0]  st_ff;

   logic [MAX_SATS-1:0] used_ff;
   logic [9:0]  eid  [MAX_SATS];
   logic [7:0]  eel  [MAX_SATS];
   logic        eelv [MAX_SATS];
   logic [8:0]  eaz  [MAX_SATS];
   logic        eazv [MAX_SATS];
   logic [6:0]  esnr [MAX_SATS];
   logic [31:0] etim [MAX_SATS];

   // Cell chain
   gsv_pkg::search_type link [MAX_SATS+1];
   logic [MAX_SATS-1:0] hit, fhit;
   gsv_pkg::search_type head;

   assign link[0] = head;
   for (genvar g = 0; g < MAX_SATS; g++) begin : g_cell
      gsv_cell u_cell (
         .clock(clock), .reset(reset), .used(used_ff[g]), .id(eid[g]),
         .prev(link[g]), .hit(hit[g]), .free_hit(fhit[g]), .next_ff(link[g+1])
      );
   end

   // The word enters cell k when the walk counter reads k.
   logic          hit_now, fhit_now;
   logic [SW-1:0] cidx;
   always_comb begin
      head = '0;
      head.active = (state_ff == S_SEARCH) && (cnt_ff == '0);
      head.id = sid_ff;
      cidx = cnt_ff[SW-1:0];
      hit_now  = (state_ff == S_SEARCH) && hit[cidx];
      fhit_now = (state_ff == S_SEARCH) && fhit[cidx];
   end

   // Field close decode for the byte on the input.
   logic is_close, is_digit, is_ws, bad_eff, out_busy;
   logic [14:0] acc_mul;
   logic [10:0] acc_next;
   logic [10:0] v;
   always_comb begin
      is_close = (req_text_byte == gsv_pkg::CHAR_COMMA) || req_last_byte;
      is_digit = (req_text_byte >= gsv_pkg::CHAR_ZERO) && (req_text_byte <= gsv_pkg::CHAR_NINE);
      is_ws    = (req_text_byte == gsv_pkg::CHAR_SPACE) || (req_text_byte == gsv_pkg::CHAR_TAB);
      bad_eff  = bad_ff || (empty_ff && neg_ff);
      acc_mul  = {4'd0, acc_ff} * 15'd10 + {7'd0, req_text_byte - gsv_pkg::CHAR_ZERO};
      acc_next = (acc_mul > {4'd0, gsv_pkg::ACC_MAX}) ? gsv_pkg::ACC_MAX : acc_mul[10:0];
      v = acc_ff;
   end

   assign out_busy = rsp_valid && !rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && !out_busy;

   // A new result word is loaded only when the output register is free or being taken.
   logic rsp_load;
   assign rsp_load = ((state_ff == S_REC) || (state_ff == S_STAT_OUT)) && !out_busy;

   logic [7:0] el_val;
   logic [6:0] v99;
   logic [8:0] v359;
   always_comb begin
      el_val = (v > 11'd90) ? 8'd90 : v[7:0];
      if (neg_ff) el_val = 8'd0 - el_val;
      v99  = (v > 11'd99) ? 7'd99 : v[6:0];
      v359 = (v > 11'd359) ? 9'd359 : v[8:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff <= '0; acc_ff <= '0; empty_ff <= 1'b1; neg_ff <= 1'b0; bad_ff <= 1'b0;
         sel_ff <= 1'b0; view_ff <= '0; skip_ff <= gsv_pkg::ST_OK;
         used_ff <= '0; rsp_valid <= 1'b0; cnt_ff <= '0;
      end else begin
         if (rsp_load) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  last_ff <= req_last_byte;
                  utc_ff  <= req_utc_time;
                  if (skip_ff != gsv_pkg::ST_OK) begin
                     if (req_last_byte) begin
                        st_ff <= skip_ff;
                        state_ff <= S_STAT_OUT;
                     end
                  end else if (is_close) begin
                     acc_ff <= '0; empty_ff <= 1'b1; neg_ff <= 1'b0; bad_ff <= 1'b0;
                     st_ff <= gsv_pkg::ST_OK;
                     if (pos_ff >= gsv_pkg::POS_SNR) pos_ff <= gsv_pkg::POS_ID;
                     else pos_ff <= pos_ff + 3'd1;
                     if (pos_ff == gsv_pkg::POS_INVIEW) begin
                        if (bad_eff) begin
                           st_ff <= gsv_pkg::ST_NUMBER;
                           skip_ff <= gsv_pkg::ST_NUMBER;
                        end else if (!empty_ff) begin
                           view_ff <= (v > 11'd255) ? 8'd255 : v[7:0];
                        end
                        if (req_last_byte) state_ff <= S_STAT_OUT;
                     end else if (pos_ff == gsv_pkg::POS_ID) begin
                        sel_ff <= 1'b0;
                        if (bad_eff) begin
                           st_ff <= gsv_pkg::ST_NUMBER;
                           skip_ff <= gsv_pkg::ST_NUMBER;
                           if (req_last_byte) state_ff <= S_STAT_OUT;
                        end else if (empty_ff) begin
                           if (req_last_byte) state_ff <= S_STAT_OUT;
                        end else begin
                           sid_ff <= (v > 11'd1023) ? 10'd1023 : v[9:0];
                           cnt_ff <= '0; found_ff <= 1'b0; free_ff <= 1'b0;
                           state_ff <= S_SEARCH;
                        end
                     end else if (pos_ff >= gsv_pkg::POS_ELEV && pos_ff <= gsv_pkg::POS_SNR
                                  && sel_ff) begin
                        if (bad_eff) begin
                           st_ff <= gsv_pkg::ST_NUMBER;
                           skip_ff <= gsv_pkg::ST_NUMBER;
                           if (req_last_byte) state_ff <= S_STAT_OUT;
                        end else begin
                           if (pos_ff == gsv_pkg::POS_ELEV) begin
                              eelv[slot_ff] <= !empty_ff;
                              if (!empty_ff) eel[slot_ff] <= el_val;
                           end else if (pos_ff == gsv_pkg::POS_AZ) begin
                              eazv[slot_ff] <= !empty_ff;
                              if (!empty_ff) eaz[slot_ff] <= v359;
                           end else if (!empty_ff) begin
                              esnr[slot_ff] <= v99;
                           end
                           if (pos_ff == gsv_pkg::POS_SNR) sel_ff <= 1'b0;
                           state_ff <= S_REC;
                        end
                     end else begin
                        if (pos_ff == gsv_pkg::POS_SNR) sel_ff <= 1'b0;
                        if (req_last_byte) state_ff <= S_STAT_OUT;
                     end
                  end else if (is_ws) begin
                     skip_ff <= gsv_pkg::ST_SYNTAX;
                  end else if (is_digit) begin
                     acc_ff <= acc_next;
                     empty_ff <= 1'b0;
                  end else if (req_text_byte == gsv_pkg::CHAR_MINUS && pos_ff == gsv_pkg::POS_ELEV
                               && empty_ff && !neg_ff && !bad_ff) begin
                     neg_ff <= 1'b1;
                  end else begin
                     bad_ff <= 1'b1;
                  end
               end
            end
            S_SEARCH: begin
               if (hit_now) begin
                  found_ff <= 1'b1; fslot_ff <= cidx;
               end
               if (fhit_now) begin
                  free_ff <= 1'b1; eslot_ff <= cidx;
               end
               if (cnt_ff == CW'(MAX_SATS - 1)) begin
                  if (found_ff || hit_now) begin
                     slot_ff <= hit_now ? cidx : fslot_ff;
                     etim[hit_now ? cidx : fslot_ff] <= utc_ff;
                     sel_ff <= 1'b1;
                     state_ff <= S_REC;
                  end else if (free_ff || fhit_now) begin
                     slot_ff <= fhit_now ? cidx : eslot_ff;
                     used_ff[fhit_now ? cidx : eslot_ff] <= 1'b1;
                     eid [fhit_now ? cidx : eslot_ff] <= sid_ff;
                     eel [fhit_now ? cidx : eslot_ff] <= '0;
                     eelv[fhit_now ? cidx : eslot_ff] <= 1'b0;
                     eaz [fhit_now ? cidx : eslot_ff] <= '0;
                     eazv[fhit_now ? cidx : eslot_ff] <= 1'b0;
                     esnr[fhit_now ? cidx : eslot_ff] <= '0;
                     etim[fhit_now ? cidx : eslot_ff] <= utc_ff;
                     sel_ff <= 1'b1;
                     state_ff <= S_REC;
                  end else begin
                     st_ff <= gsv_pkg::ST_FULL;
                     skip_ff <= gsv_pkg::ST_FULL;
                     state_ff <= last_ff ? S_STAT_OUT : S_IDLE;
                  end
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            S_REC: begin
               if (!out_busy) begin
                  rsp_result_kind <= 1'b0;
                  rsp_status <= gsv_pkg::ST_OK;
                  rsp_sats_in_view <= view_ff;
                  rsp_sat_id <= eid[slot_ff];
                  rsp_table_slot <= 5'(slot_ff);
                  rsp_elevation_deg <= eel[slot_ff];
                  rsp_elevation_ok <= eelv[slot_ff];
                  rsp_azimuth_deg <= eaz[slot_ff];
                  rsp_azimuth_ok <= eazv[slot_ff];
                  rsp_snr_db <= esnr[slot_ff];
                  rsp_reported_time <= etim[slot_ff];
                  state_ff <= last_ff ? S_STAT_OUT : S_IDLE;
               end
            end
            S_REC_OUT: state_ff <= S_IDLE;
            S_STAT_OUT: begin
               if (!out_busy) begin
                  rsp_result_kind <= 1'b1;
                  rsp_status <= st_ff;
                  rsp_sats_in_view <= view_ff;
                  rsp_sat_id <= '0; rsp_table_slot <= '0; rsp_elevation_deg <= '0;
                  rsp_elevation_ok <= 1'b0; rsp_azimuth_deg <= '0; rsp_azimuth_ok <= 1'b0;
                  rsp_snr_db <= '0; rsp_reported_time <= '0;
                  pos_ff <= '0; acc_ff <= '0; empty_ff <= 1'b1; neg_ff <= 1'b0;
                  bad_ff <= 1'b0; sel_ff <= 1'b0; skip_ff <= gsv_pkg::ST_OK;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- sv/gsv_cell.sv -----
// One table cell: tells whether its entry is used and whether it holds the id in the
// search word passing by, and passes the word on. Depends on gsv_pkg.
module gsv_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                used,
   input  logic [9:0]          id,
   input  gsv_pkg::search_type prev,
   output logic                hit,
   output logic                free_hit,
   output gsv_pkg::search_type next_ff
);
   gsv_pkg::search_type next_in;

   always_comb begin
      hit      = prev.active && !prev.found && used && (id == prev.id);
      free_hit = prev.active && !prev.free_seen && !used;
      next_in  = prev;
      next_in.found     = prev.found || hit;
      next_in.free_seen = prev.free_seen || !used;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff <= '0;
      end else begin
         next_ff <= next_in;
      end
   end
endmodule
